// ----- rtl/lpht_pkg.sv -----
// Shared constants, codes and types of the linear probing hash table.
package lpht_pkg;

  localparam int unsigned TableSize = 16;
  localparam int unsigned SlotBits  = $clog2(TableSize);
  localparam int unsigned KeyBits   = 32;

  typedef enum logic {
    CmdInsert = 1'b0,
    CmdSearch = 1'b1
  } cmd_e;

  typedef enum logic {
    StIdle  = 1'b0,
    StProbe = 1'b1
  } state_e;

  typedef struct packed {
    logic                en;
    logic [SlotBits-1:0] addr;
    logic [KeyBits-1:0]  key;
  } store_wr_t;

endpackage

// ----- rtl/linear_probe_hash_table_top.sv -----
// An item probes k slots (k from 1 to 16), one per cycle while the output is not stalled,
// through the key memory read port. The result is registered at the end of the last probe.
// A new transaction is accepted only once the result of the last one has been registered.
// Reset is asynchronous and active low; it clears all occupied flags and the control state.
// Key storage is not reset; a slot's key is only compared once the slot has been written.
module linear_probe_hash_table_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] key
  input  logic       s_axis_tuser,   // [0] command
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [3:0] slot, [7:4] zero
  output logic       m_axis_tuser    // [0] success
);

  lpht_pkg::store_wr_t           wr;
  logic [lpht_pkg::SlotBits-1:0] rd_addr;
  logic [lpht_pkg::KeyBits-1:0]  rd_key;
  logic                          rd_occ;
  logic [lpht_pkg::SlotBits-1:0] out_slot;

  lpht_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_cmd_i      (s_axis_tuser),
    .in_key_i      (s_axis_tdata),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_success_o (m_axis_tuser),
    .out_slot_o    (out_slot),
    .wr_o          (wr),
    .rd_addr_o     (rd_addr),
    .rd_key_i      (rd_key),
    .rd_occ_i      (rd_occ)
  );

  lpht_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_key_o  (rd_key),
    .rd_occ_o  (rd_occ)
  );

  assign m_axis_tdata = {4'b0000, out_slot};

endmodule

// ----- rtl/lpht_store.sv -----
// Slot store: key memory with registered read and per-slot occupied flags.
module lpht_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lpht_pkg::store_wr_t           wr_i,
  input  logic [lpht_pkg::SlotBits-1:0] rd_addr_i,
  output logic [lpht_pkg::KeyBits-1:0]  rd_key_o,
  output logic                          rd_occ_o
);

  logic [lpht_pkg::KeyBits-1:0]   key_mem [lpht_pkg::TableSize];
  logic [lpht_pkg::TableSize-1:0] occ_q;
  logic [lpht_pkg::KeyBits-1:0]   rd_key_q;
  logic                           rd_occ_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      key_mem[wr_i.addr] <= wr_i.key;
    end
    rd_key_q <= key_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q    <= '0;
      rd_occ_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        occ_q[wr_i.addr] <= 1'b1;
      end
      rd_occ_q <= occ_q[rd_addr_i];
    end
  end

  assign rd_key_o = rd_key_q;
  assign rd_occ_o = rd_occ_q;

endmodule

// ----- rtl/lpht_ctrl.sv -----
// Probe sequencer with the shared key comparator and the result register.
module lpht_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          in_cmd_i,
  input  logic [lpht_pkg::KeyBits-1:0]  in_key_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          out_success_o,
  output logic [lpht_pkg::SlotBits-1:0] out_slot_o,
  output lpht_pkg::store_wr_t           wr_o,
  output logic [lpht_pkg::SlotBits-1:0] rd_addr_o,
  input  logic [lpht_pkg::KeyBits-1:0]  rd_key_i,
  input  logic                          rd_occ_i
);

  localparam logic [lpht_pkg::SlotBits-1:0] LastCount =
    lpht_pkg::SlotBits'(lpht_pkg::TableSize - 1);

  lpht_pkg::state_e              state_q, state_d;
  lpht_pkg::cmd_e                cmd_q, cmd_d;
  logic [lpht_pkg::KeyBits-1:0]  key_q, key_d;
  logic [lpht_pkg::SlotBits-1:0] probe_q, probe_d;
  logic [lpht_pkg::SlotBits-1:0] count_q, count_d;
  logic                          out_valid_q, out_valid_d;
  logic                          out_success_q, out_success_d;
  logic [lpht_pkg::SlotBits-1:0] out_slot_q, out_slot_d;
  logic                          out_busy;
  logic                          key_match;

  assign out_busy  = out_valid_q && !out_ready_i;
  assign key_match = (rd_key_i == key_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lpht_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q         <= cmd_d;
    key_q         <= key_d;
    probe_q       <= probe_d;
    count_q       <= count_d;
    out_success_q <= out_success_d;
    out_slot_q    <= out_slot_d;
  end

  always_comb begin
    state_d       = state_q;
    cmd_d         = cmd_q;
    key_d         = key_q;
    probe_d       = probe_q;
    count_d       = count_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_success_d = out_success_q;
    out_slot_d    = out_slot_q;
    in_ready_o    = 1'b0;
    wr_o.en       = 1'b0;
    wr_o.addr     = probe_q;
    wr_o.key      = key_q;
    rd_addr_o     = probe_q;
    case (state_q)
      lpht_pkg::StIdle: begin
        in_ready_o = 1'b1;
        rd_addr_o  = in_key_i[lpht_pkg::SlotBits-1:0];
        if (in_valid_i) begin
          cmd_d   = lpht_pkg::cmd_e'(in_cmd_i);
          key_d   = in_key_i;
          probe_d = in_key_i[lpht_pkg::SlotBits-1:0];
          count_d = '0;
          state_d = lpht_pkg::StProbe;
        end
      end
      lpht_pkg::StProbe: begin
        if (!out_busy) begin
          if (!rd_occ_i) begin
            out_valid_d = 1'b1;
            state_d     = lpht_pkg::StIdle;
            if (cmd_q == lpht_pkg::CmdInsert) begin
              wr_o.en       = 1'b1;
              out_success_d = 1'b1;
              out_slot_d    = probe_q;
            end else begin
              out_success_d = 1'b0;
              out_slot_d    = '0;
            end
          end else if (cmd_q == lpht_pkg::CmdSearch && key_match) begin
            out_valid_d   = 1'b1;
            out_success_d = 1'b1;
            out_slot_d    = probe_q;
            state_d       = lpht_pkg::StIdle;
          end else if (count_q == LastCount) begin
            out_valid_d   = 1'b1;
            out_success_d = 1'b0;
            out_slot_d    = '0;
            state_d       = lpht_pkg::StIdle;
          end else begin
            probe_d   = probe_q + 1'b1;
            count_d   = count_q + 1'b1;
            rd_addr_o = probe_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = lpht_pkg::StIdle;
      end
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign out_success_o = out_success_q;
  assign out_slot_o    = out_slot_q;

endmodule

// ----- tb/linear_probe_hash_table_top_test.sv -----
// Self-checking testbench of the linear probing hash table: directed and random inserts and searches.
module linear_probe_hash_table_top_test;
  import lpht_pkg::*;

  typedef struct packed {
    logic                success;
    logic [SlotBits-1:0] slot;
  } lookup_result_t;

  localparam int unsigned RandomItems   = 1900;
  localparam int unsigned PressureItems = 40;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned DrainLimit    = 10000;
  localparam int unsigned SettleCycles  = 40;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata  = '0;  // [31:0] key
  logic                s_axis_tuser  = CmdInsert;  // [0] command
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;  // [3:0] slot, [7:4] zero
  logic                m_axis_tuser;  // [0] success

  logic [KeyBits-1:0]  table_keys [TableSize];
  logic                table_used [TableSize];
  logic [KeyBits-1:0]  inserted_keys [$];
  lookup_result_t      pending_lookups [$];
  lookup_result_t      oldest_lookup;
  int unsigned         error_count = 0;
  int unsigned         sink_stall  = 0;
  logic                gaps_on     = 1'b1;
  logic                hold_active = 1'b0;
  event                hold_go;

  linear_probe_hash_table_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic lookup_result_t probe_table(input cmd_e cmd, input logic [KeyBits-1:0] key);
    lookup_result_t      res;
    logic [SlotBits-1:0] idx;
    res = '0;
    idx = SlotBits'(key % TableSize);
    for (int n = 0; n < TableSize; n++) begin
      if (!table_used[idx]) begin
        if (cmd == CmdInsert) begin
          table_keys[idx] = key;
          table_used[idx] = 1'b1;
          inserted_keys.push_back(key);
          res.success = 1'b1;
          res.slot    = idx;
        end
        return res;
      end
      if (cmd == CmdSearch && table_keys[idx] == key) begin
        res.success = 1'b1;
        res.slot    = idx;
        return res;
      end
      idx = SlotBits'((int'(idx) + 1) % TableSize);
    end
    return res;
  endfunction

  task automatic send_op(input cmd_e cmd, input logic [KeyBits-1:0] key);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= key;
    s_axis_tuser  <= cmd;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    pending_lookups.push_back(probe_table(cmd, key));
    gap = gaps_on ? idle_len() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_active) begin
      m_axis_tready <= 1'b0;
    end else if (sink_stall != 0) begin
      m_axis_tready <= 1'b0;
      sink_stall    <= sink_stall - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (gaps_on) sink_stall <= idle_len();
    end
  end

  initial forever begin
    @(hold_go);
    hold_active <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_active <= 1'b0;
  end

  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_lookups.size() == 0) begin
        $display("%0t: unexpected result: success %0d slot %0d", $time, m_axis_tuser,
                 m_axis_tdata[3:0]);
        error_count++;
      end else begin
        oldest_lookup = pending_lookups.pop_front();
        if (m_axis_tuser !== oldest_lookup.success) begin
          $display("%0t: success mismatch: expected %0d actual %0d", $time,
                   oldest_lookup.success, m_axis_tuser);
          error_count++;
        end
        if (m_axis_tdata[3:0] !== oldest_lookup.slot) begin
          $display("%0t: slot mismatch: expected %0d actual %0d", $time,
                   oldest_lookup.slot, m_axis_tdata[3:0]);
          error_count++;
        end
        if (m_axis_tdata[7:4] !== 4'h0) begin
          $display("%0t: padding mismatch: expected 0 actual %0h", $time, m_axis_tdata[7:4]);
          error_count++;
        end
      end
    end
  end

  task automatic test_directed_basics();
    send_op(CmdSearch, 32'h0000_0000);
    send_op(CmdInsert, 32'h0000_0000);
    send_op(CmdInsert, 32'hFFFF_FFFF);
    send_op(CmdInsert, 32'h0000_001F);
    send_op(CmdInsert, 32'h0000_0000);
    send_op(CmdSearch, 32'h0000_0000);
    send_op(CmdSearch, 32'h0000_001F);
    send_op(CmdSearch, 32'h0000_0010);
    send_op(CmdSearch, 32'h8000_0005);
    send_op(CmdInsert, 32'h8000_0005);
    send_op(CmdSearch, 32'h0000_0005);
    send_op(CmdSearch, 32'hFFFF_FFFF);
  endtask

  task automatic test_random_mix();
    cmd_e               cmd;
    logic [KeyBits-1:0] key;
    int unsigned        pick;
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 150 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      cmd  = ($urandom_range(0, 15) == 0) ? CmdInsert : CmdSearch;
      pick = $urandom_range(0, 9);
      key  = $urandom;
      if (inserted_keys.size() != 0 && pick < 5) begin
        key = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
      end else if (inserted_keys.size() != 0 && pick == 5) begin
        key = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
        key[$urandom_range(0, KeyBits - 1)] ^= 1'b1;
      end else if (pick == 6) begin
        key[3:0] = 4'($urandom_range(13, 18));
      end else if (pick == 7) begin
        case ($urandom_range(0, 3))
          0: key = 32'h0000_0000;
          1: key = 32'hFFFF_FFFF;
          2: key = 32'h8000_0000;
          default: key = 32'h7FFF_FFFF;
        endcase
      end
      send_op(cmd, key);
    end
  endtask

  task automatic test_output_backpressure();
    gaps_on = 1'b0;
    ->hold_go;
    for (int n = 0; n < PressureItems; n++) begin
      send_op($urandom_range(0, 1) ? CmdSearch : CmdInsert,
              inserted_keys[$urandom_range(0, inserted_keys.size() - 1)]);
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_table_full();
    while (inserted_keys.size() < TableSize) send_op(CmdInsert, $urandom);
    send_op(CmdInsert, 32'h1234_5670);
    send_op(CmdSearch, 32'hDEAD_BEEF);
    send_op(CmdSearch, inserted_keys[inserted_keys.size() - 1]);
  endtask

  initial begin
    int unsigned drain_cycles;
    for (int i = 0; i < TableSize; i++) table_used[i] = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_basics();
    test_random_mix();
    test_output_backpressure();
    test_table_full();
    s_axis_tvalid <= 1'b0;
    drain_cycles = 0;
    while (pending_lookups.size() != 0 && drain_cycles < DrainLimit) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (SettleCycles) @(posedge clk_i);
    if (pending_lookups.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_lookups.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/lpht_pkg.sv
rtl/lpht_store.sv
rtl/lpht_ctrl.sv
rtl/linear_probe_hash_table_top.sv
tb/linear_probe_hash_table_top_test.sv
